/* src/pwrsrc_pkg.sv */
package pwrsrc_pkg;

    // Command codes carried by an input transaction
    typedef enum logic [1:0] {
        CMD_POWER_EVENT = 2'd0,
        CMD_TICK        = 2'd1,
        CMD_HOST_OK     = 2'd2,
        CMD_IDLE        = 2'd3
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_LOW_BATTERY_LEVEL    = 2'd0,
        CFG_DEASSERT_DELAY_TICKS = 2'd1,
        CFG_DC_SOURCE_CODE       = 2'd2,
        CFG_USBC_SOURCE_CODE     = 2'd3
    } t_cfg_idx;

    // Power source classes: bit 1 is battery, bit 0 is external power
    localparam logic [1:0] CLASS_UNKNOWN   = 2'd0;
    localparam logic [1:0] CLASS_AC_ONLY   = 2'd1;
    localparam logic [1:0] CLASS_BATT_ONLY = 2'd2;
    localparam logic [1:0] CLASS_AC_BATT   = 2'd3;

    // Configuration reset values
    localparam logic [6:0]  LOW_BATTERY_RESET = 7'd10;
    localparam logic [15:0] DEASSERT_RESET    = 16'd2000;
    localparam logic [3:0]  DC_CODE_RESET     = 4'd0;
    localparam logic [3:0]  USBC_CODE_RESET   = 4'd1;

    // Rating = mA * mV / 50000, saturated at 4095.
    // 50000 = 16 * 3125: shift by 4, then multiply by ceil(2^36 / 3125).
    localparam logic [11:0] RATING_MAX         = 12'd4095;
    localparam logic [31:0] RATING_SAT_PRODUCT = 32'd204800000;
    localparam logic [24:0] RATING_RECIP       = 25'd21990233;

    typedef struct packed {
        t_cmd        cmd;
        logic        battery_present;
        logic        external_present;
        logic        port_disconnected;
        logic [6:0]  battery_charge;
        logic [15:0] charger_milliamps;
        logic [15:0] charger_millivolts;
        logic [7:0]  host_sequence;
    } t_in;

    typedef struct packed {
        logic        throttle_active;
        logic [1:0]  source_class;
        logic [7:0]  status_byte;
        logic [11:0] rating_units;
        logic        host_event;
    } t_out;

endpackage

/* src/power_source_report_prochot.sv */
// Power source report and hard-throttle control.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one command per
// transaction: power event, timer tick, host OK or idle. Every transaction
// gives exactly one result on the output channel (o_out_valid / i_out_ready /
// o_out_data): throttle state, source class, status byte, rating in 50 mW
// units and a host event flag set when the transaction made a report.
// The configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
// i_cfg_data) is always ready; write it only while the block is idle.
// Each result passes through the input register, product register, quotient
// register and output register, in that order.
// Throughput: one transaction per cycle; the two-stage rating multiply
// pipeline is what sets the depth, the state update is a single stage.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_ready drops; nothing is dropped or repeated.
// Reset (synchronous, active low) clears the pipeline, sets source class
// unknown, sequence, status and rating to zero, throttle off, the deassert
// timer disarmed, and loads the configuration defaults.
module power_source_report_prochot (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pwrsrc_pkg::t_in    i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pwrsrc_pkg::t_out   o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  pwrsrc_pkg::t_cfg_idx i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import pwrsrc_pkg::*;

    // Configuration registers
    logic [6:0]  r_low_batt;
    logic [15:0] r_delay_cfg;
    logic [3:0]  r_dc_code;
    logic [3:0]  r_usbc_code;

    // Pipeline
    logic        w_adv;
    logic        r_s1_valid, r_s2_valid, r_s3_valid;
    t_in         r_s1, r_s2, r_s3;
    logic [11:0] w_rating;

    // Block state
    logic [1:0]  r_source, n_source;
    logic [3:0]  r_seq, n_seq;
    logic        r_throttle, n_throttle;
    logic [15:0] r_count, n_count;
    logic        r_armed, n_armed;
    logic [7:0]  r_status, n_status;
    logic [11:0] r_rating, n_rating;
    logic        n_host_event;

    logic        r_out_valid;
    t_out        r_out_data;

    // Step decode
    logic [1:0]  w_cls;
    logic        w_report;
    logic        w_dc_path;
    logic [3:0]  w_seq_inc;
    logic [15:0] w_count_dec;

    // Advance the whole pipeline unless a result is waiting on a stalled receiver
    assign w_adv       = ~r_out_valid | i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_batt  <= LOW_BATTERY_RESET;
            r_delay_cfg <= DEASSERT_RESET;
            r_dc_code   <= DC_CODE_RESET;
            r_usbc_code <= USBC_CODE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOW_BATTERY_LEVEL:    r_low_batt  <= i_cfg_data[6:0];
                CFG_DEASSERT_DELAY_TICKS: r_delay_cfg <= i_cfg_data;
                CFG_DC_SOURCE_CODE:       r_dc_code   <= i_cfg_data[3:0];
                CFG_USBC_SOURCE_CODE:     r_usbc_code <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1 <= i_in_data;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    // Rating arithmetic, aligned with stages two and three
    pwrsrc_rating u_rating (
        .i_clk        (i_clk),
        .i_en         (w_adv),
        .i_milliamps  (r_s1.charger_milliamps),
        .i_millivolts (r_s1.charger_millivolts),
        .o_rating     (w_rating)
    );

    // Classify: battery flag gives bit 1, external flag gives bit 0
    assign w_cls       = {r_s3.battery_present, r_s3.external_present};
    assign w_report    = (r_source != w_cls) ||
                         (((w_cls == CLASS_BATT_ONLY) || (w_cls == CLASS_AC_BATT)) &&
                          (r_s3.battery_charge <= r_low_batt));
    assign w_dc_path   = r_s3.port_disconnected || (w_cls == CLASS_BATT_ONLY);
    assign w_seq_inc   = r_seq + 4'd1;
    assign w_count_dec = (r_count != 16'd0) ? (r_count - 16'd1) : 16'd0;

    // Next state for the transaction in stage three
    always_comb begin
        n_source     = r_source;
        n_seq        = r_seq;
        n_throttle   = r_throttle;
        n_count      = r_count;
        n_armed      = r_armed;
        n_status     = r_status;
        n_rating     = r_rating;
        n_host_event = 1'b0;
        unique case (r_s3.cmd)
            CMD_POWER_EVENT: begin
                n_source = w_cls;
                if (w_report) begin
                    n_host_event = 1'b1;
                    n_count      = r_delay_cfg;
                    n_armed      = 1'b1;
                    if (w_dc_path) begin
                        n_rating   = 12'd0;
                        n_seq      = w_seq_inc;
                        n_throttle = 1'b1;
                        n_status   = {w_seq_inc, r_dc_code};
                    end else begin
                        n_rating = w_rating;
                        n_status = {r_seq, r_usbc_code};
                    end
                end
            end
            CMD_TICK: begin
                if (r_armed) begin
                    n_count = w_count_dec;
                    if (w_count_dec == 16'd0) begin
                        n_armed    = 1'b0;
                        n_throttle = 1'b0;
                    end
                end
            end
            CMD_HOST_OK: begin
                if (r_throttle && (r_s3.host_sequence == {4'd0, r_status[7:4]})) begin
                    n_throttle = 1'b0;
                    n_armed    = 1'b0;
                    n_count    = 16'd0;
                end
            end
            CMD_IDLE: ;
            default: ;
        endcase
    end

    // Commit state for each transaction leaving stage three
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source   <= CLASS_UNKNOWN;
            r_seq      <= 4'd0;
            r_throttle <= 1'b0;
            r_count    <= 16'd0;
            r_armed    <= 1'b0;
            r_status   <= 8'd0;
            r_rating   <= 12'd0;
        end else if (w_adv && r_s3_valid) begin
            r_source   <= n_source;
            r_seq      <= n_seq;
            r_throttle <= n_throttle;
            r_count    <= n_count;
            r_armed    <= n_armed;
            r_status   <= n_status;
            r_rating   <= n_rating;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s3_valid) begin
            r_out_data.throttle_active <= n_throttle;
            r_out_data.source_class    <= n_source;
            r_out_data.status_byte     <= n_status;
            r_out_data.rating_units    <= n_rating;
            r_out_data.host_event      <= n_host_event;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* src/pwrsrc_rating.sv */
module pwrsrc_rating (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_milliamps,
    input  logic [15:0] i_millivolts,
    output logic [11:0] o_rating
);
    import pwrsrc_pkg::*;

    logic [31:0] r_prod;
    logic [11:0] r_quot;
    logic        w_sat;
    logic [48:0] w_recip_prod;

    // Stage one: current times voltage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {16'd0, i_milliamps} * {16'd0, i_millivolts};
        end
    end

    // Stage two: divide by 50000 through the reciprocal, saturate
    assign w_sat        = (r_prod >= RATING_SAT_PRODUCT);
    assign w_recip_prod = {25'd0, r_prod[27:4]} * {24'd0, RATING_RECIP};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= w_sat ? RATING_MAX : w_recip_prod[47:36];
        end
    end

    assign o_rating = r_quot;

endmodule

/* verif/tb_power_source_report_prochot.sv */
module tb_power_source_report_prochot;
    import pwrsrc_pkg::*;

    // One pending input transaction; follow_seq makes a host OK carry the
    // sequence the block currently reports, picked when the item is loaded
    typedef struct packed {
        t_in data;
        logic follow_seq;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic o_in_ready;
    t_in in_data = '0;
    logic o_out_valid;
    logic out_ready = 1'b0;
    t_out o_out_data;
    logic cfg_valid = 1'b0;
    logic o_cfg_ready;
    t_cfg_idx cfg_index = CFG_LOW_BATTERY_LEVEL;
    logic [15:0] cfg_data = '0;

    t_pending pending_cmds[$];
    t_out expected_reports[$];
    int send_idle_pct = 20;
    int recv_stall_pct = 48;
    int failures = 0;

    // Shadow configuration
    logic [6:0] low_level = LOW_BATTERY_RESET;
    logic [15:0] delay_ticks = DEASSERT_RESET;
    logic [3:0] dc_code = DC_CODE_RESET;
    logic [3:0] usbc_code = USBC_CODE_RESET;

    // Shadow state of the block
    logic [1:0] src_class = CLASS_UNKNOWN;
    logic [3:0] seq_num = 4'd0;
    logic throttle = 1'b0;
    logic [15:0] hold_count = 16'd0;
    logic hold_armed = 1'b0;
    logic [7:0] status = 8'd0;
    logic [11:0] rating = 12'd0;

    power_source_report_prochot i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one accepted transaction to the shadow state and queue its result
    task automatic advance_power_state(input t_in d);
        logic [1:0] prev_class;
        logic [1:0] new_class;
        logic [31:0] product;
        logic [31:0] quotient;
        logic reported;
        t_out res;
        reported = 1'b0;
        case (d.cmd)
            CMD_POWER_EVENT: begin
                prev_class = src_class;
                if (d.external_present)
                    new_class = d.battery_present ? CLASS_AC_BATT : CLASS_AC_ONLY;
                else
                    new_class = d.battery_present ? CLASS_BATT_ONLY : CLASS_UNKNOWN;
                src_class = new_class;
                // Report on a class change, or on battery at low charge
                if (prev_class != new_class ||
                    (new_class[1] && d.battery_charge <= low_level)) begin
                    reported = 1'b1;
                    if (d.port_disconnected || new_class == CLASS_BATT_ONLY) begin
                        rating = 12'd0;
                        seq_num = seq_num + 4'd1;
                        throttle = 1'b1;
                        status = {seq_num, dc_code};
                    end else begin
                        product = {16'd0, d.charger_milliamps} *
                                  {16'd0, d.charger_millivolts};
                        quotient = product / 32'd50000;
                        rating = (quotient > 32'd4095) ? RATING_MAX : quotient[11:0];
                        status = {seq_num, usbc_code};
                    end
                    hold_count = delay_ticks;
                    hold_armed = 1'b1;
                end
            end
            CMD_TICK: begin
                // Count down the deassert timer, release throttle at zero
                if (hold_armed) begin
                    if (hold_count != 16'd0)
                        hold_count = hold_count - 16'd1;
                    if (hold_count == 16'd0) begin
                        hold_armed = 1'b0;
                        throttle = 1'b0;
                    end
                end
            end
            CMD_HOST_OK: begin
                if (throttle && d.host_sequence == {4'd0, status[7:4]}) begin
                    throttle = 1'b0;
                    hold_armed = 1'b0;
                    hold_count = 16'd0;
                end
            end
            default: ;
        endcase
        res.throttle_active = throttle;
        res.source_class = src_class;
        res.status_byte = status;
        res.rating_units = rating;
        res.host_event = reported;
        expected_reports.push_back(res);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Input driver: predict on acceptance, then load the next transaction
    always @(posedge i_clk) begin : drive_in
        t_pending nxt;
        if (i_rst_n) begin
            if (in_valid && o_in_ready)
                advance_power_state(in_data);
            if (!in_valid || o_in_ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_cmds.pop_front();
                    if (nxt.follow_seq)
                        nxt.data.host_sequence = {4'd0, status[7:4]};
                    in_data <= nxt.data;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin : watch_out
        t_out want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected result transaction %h", o_out_data);
                failures++;
            end else begin
                want = expected_reports.pop_front();
                check_field("throttle_active", 32'(want.throttle_active),
                            32'(o_out_data.throttle_active));
                check_field("source_class", 32'(want.source_class),
                            32'(o_out_data.source_class));
                check_field("status_byte", 32'(want.status_byte),
                            32'(o_out_data.status_byte));
                check_field("rating_units", 32'(want.rating_units),
                            32'(o_out_data.rating_units));
                check_field("host_event", 32'(want.host_event),
                            32'(o_out_data.host_event));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic push_cmd(input t_cmd cmd, input logic batt, input logic ext,
                            input logic disc, input logic [6:0] charge,
                            input logic [15:0] ma, input logic [15:0] mv,
                            input logic [7:0] seq, input logic follow);
        t_pending p;
        p.data.cmd = cmd;
        p.data.battery_present = batt;
        p.data.external_present = ext;
        p.data.port_disconnected = disc;
        p.data.battery_charge = charge;
        p.data.charger_milliamps = ma;
        p.data.charger_millivolts = mv;
        p.data.host_sequence = seq;
        p.follow_seq = follow;
        pending_cmds.push_back(p);
    endtask

    // Write all four registers back to back; hold valid high between them
    task automatic load_settings(input logic [6:0] lvl, input logic [15:0] ticks,
                                 input logic [3:0] dc, input logic [3:0] usbc);
        logic [15:0] vals [4];
        vals[0] = {9'd0, lvl};
        vals[1] = ticks;
        vals[2] = {12'd0, dc};
        vals[3] = {12'd0, usbc};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= t_cfg_idx'(i);
            cfg_data <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (t_cfg_idx'(i))
                CFG_LOW_BATTERY_LEVEL:    low_level = vals[i][6:0];
                CFG_DEASSERT_DELAY_TICKS: delay_ticks = vals[i];
                CFG_DC_SOURCE_CODE:       dc_code = vals[i][3:0];
                CFG_USBC_SOURCE_CODE:     usbc_code = vals[i][3:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Wait until every transaction is out, then let the pipeline settle
    task automatic wait_quiet();
        while (pending_cmds.size() > 0 || in_valid || expected_reports.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic queue_random_traffic(input int count);
        t_cmd cmd;
        logic [6:0] charge;
        logic [15:0] ma;
        logic [15:0] mv;
        logic [7:0] seq;
        logic follow;
        int pick;
        repeat (count) begin
            pick = $urandom_range(99);
            cmd = (pick < 45) ? CMD_POWER_EVENT : (pick < 75) ? CMD_TICK :
                  (pick < 95) ? CMD_HOST_OK : CMD_IDLE;
            // Bias charge toward the threshold, sometimes above 100
            case ($urandom_range(3))
                0: charge = 7'($urandom_range(20));
                1: charge = 7'($urandom_range(100));
                2: charge = 7'($urandom_range(127));
                default: charge = low_level + 7'($urandom_range(2)) - 7'd1;
            endcase
            case ($urandom_range(3))
                0: begin
                    ma = 16'($urandom);
                    mv = 16'($urandom);
                end
                1: begin
                    ma = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    mv = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                end
                default: begin
                    ma = 16'($urandom_range(5000, 100));
                    mv = 16'($urandom_range(20000, 5000));
                end
            endcase
            // Half the host OKs carry the live sequence
            pick = $urandom_range(3);
            follow = (pick < 2);
            seq = (pick == 2) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
            push_cmd(cmd, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     ($urandom_range(3) == 0), charge, ma, mv, seq, follow);
        end
    endtask

    initial begin : run
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: short timer so expiry and re-arm show up quickly
        load_settings(7'd10, 16'd2, 4'd5, 4'd10);
        push_cmd(CMD_IDLE, 1'b1, 1'b1, 1'b1, 7'd127, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        push_cmd(CMD_TICK, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 16'd0, 8'd0, 1'b0);
        push_cmd(CMD_HOST_OK, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 16'd0, 8'd0, 1'b0);
        push_cmd(CMD_POWER_EVENT, 1'b0, 1'b1, 1'b0, 7'd50, 16'd0, 16'd0, 8'd0, 1'b0);
        push_cmd(CMD_POWER_EVENT, 1'b0, 1'b1, 1'b0, 7'd50, 16'hFFFF, 16'hFFFF, 8'd0,
                 1'b0);
        push_cmd(CMD_POWER_EVENT, 1'b1, 1'b1, 1'b0, 7'd100, 16'hFFFF, 16'hFFFF, 8'd0,
                 1'b0);
        push_cmd(CMD_POWER_EVENT, 1'b1, 1'b1, 1'b0, 7'd10, 16'd3000, 16'd20000, 8'd0,
                 1'b0);
        push_cmd(CMD_POWER_EVENT, 1'b1, 1'b1, 1'b0, 7'd11, 16'd1, 16'd1, 8'd0, 1'b0);
        push_cmd(CMD_POWER_EVENT, 1'b1, 1'b0, 1'b0, 7'd127, 16'd100, 16'd100, 8'd0,
                 1'b0);
        push_cmd(CMD_HOST_OK, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 16'd0, 8'd0, 1'b0);
        push_cmd(CMD_HOST_OK, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 16'd0, 8'h11, 1'b0);
        push_cmd(CMD_HOST_OK, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 16'd0, 8'd1, 1'b0);
        push_cmd(CMD_POWER_EVENT, 1'b0, 1'b1, 1'b1, 7'd0, 16'd5000, 16'd20000, 8'd0,
                 1'b0);
        push_cmd(CMD_TICK, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 16'd0, 8'd0, 1'b0);
        push_cmd(CMD_TICK, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 16'd0, 8'd0, 1'b0);
        push_cmd(CMD_TICK, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 16'd0, 8'd0, 1'b0);
        push_cmd(CMD_POWER_EVENT, 1'b0, 1'b0, 1'b0, 7'd0, 16'd1, 16'd49999, 8'd0, 1'b0);
        push_cmd(CMD_POWER_EVENT, 1'b1, 1'b1, 1'b0, 7'd5, 16'd1, 16'd50000, 8'd0, 1'b0);
        push_cmd(CMD_POWER_EVENT, 1'b1, 1'b1, 1'b1, 7'd5, 16'd7, 16'd7, 8'd0, 1'b0);
        push_cmd(CMD_TICK, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 16'd0, 8'd0, 1'b0);
        push_cmd(CMD_POWER_EVENT, 1'b1, 1'b1, 1'b0, 7'd5, 16'd100, 16'd100, 8'd0, 1'b0);
        push_cmd(CMD_TICK, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 16'd0, 8'd0, 1'b0);
        push_cmd(CMD_TICK, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 16'd0, 8'd0, 1'b0);
        push_cmd(CMD_IDLE, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 16'd0, 8'd0, 1'b0);

        // Random phases, each with its own settings; pairs of phases share an idle pattern
        for (int p = 0; p < 6; p++) begin
            wait_quiet();
            case (p / 2)
                0: begin
                    send_idle_pct = 20;
                    recv_stall_pct = 48;
                end
                1: begin
                    send_idle_pct = 48;
                    recv_stall_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            case (p)
                0: load_settings(7'd0, 16'd1, 4'd0, 4'd15);
                1: load_settings(7'd127, 16'd0, 4'd15, 4'd0);
                2: load_settings(7'd100, 16'hFFFF, 4'd7, 4'd8);
                3: load_settings(LOW_BATTERY_RESET, DEASSERT_RESET,
                                 DC_CODE_RESET, USBC_CODE_RESET);
                4: load_settings(7'd50, 16'd5, 4'd9, 4'd6);
                default: load_settings(7'($urandom_range(127)), 16'($urandom_range(30)),
                                       4'($urandom_range(15)), 4'($urandom_range(15)));
            endcase
            queue_random_traffic(200);
        end

        wait_quiet();
        if (failures == 0)
            $display("tb_power_source_report_prochot OK");
        else
            $display("tb_power_source_report_prochot NOT OK");
        $finish;
    end

    // Hang guard
    initial begin
        #2000000;
        $display("tb_power_source_report_prochot NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
src/pwrsrc_pkg.sv
src/pwrsrc_rating.sv
src/power_source_report_prochot.sv
verif/tb_power_source_report_prochot.sv
